>>> src/chunk_bitmap_first_fit_allocator_top_assert.svh
// Assertion macros used by the allocator checker
`ifndef CHUNK_BITMAP_FIRST_FIT_ALLOCATOR_TOP_ASSERT_SVH
`define CHUNK_BITMAP_FIRST_FIT_ALLOCATOR_TOP_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off during reset
`define CBFFA_ASSERT_SAME(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset
`define CBFFA_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/cbffa_pkg.sv
// Package: constants, codes and types of the chunk bitmap allocator
`timescale 1ns / 1ps
package cbffa_pkg;

  localparam int unsigned NUM_CHUNKS   = 256;
  localparam int unsigned CHUNK_BYTES  = 16;
  localparam int unsigned HEADER_BYTES = 2;

  localparam int unsigned DIGIT_W     = 8;                      // chunks per map byte
  localparam int unsigned DIGIT_SEL_W = $clog2(DIGIT_W);
  localparam int unsigned MAP_BYTES   = NUM_CHUNKS / DIGIT_W;
  localparam int unsigned BCNT_W      = $clog2(MAP_BYTES);
  localparam int unsigned CHUNK_W     = $clog2(NUM_CHUNKS);
  localparam int unsigned LEN_W       = CHUNK_W + 1;            // holds NUM_CHUNKS itself
  localparam int unsigned OFF_W       = $clog2(CHUNK_BYTES);
  localparam int unsigned ADDR_W      = 12;
  localparam int unsigned REQ_W       = 12;
  localparam int unsigned SUM_W       = REQ_W + 1;
  localparam int unsigned ST_W        = 2;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_e;

  typedef enum logic [ST_W-1:0] {
    ST_GRANTED = 2'd0,
    ST_NO_ROOM = 2'd1,
    ST_FREED   = 2'd2,
    ST_UNKNOWN = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    MAP_IDLE,   // clear search state, hold map
    MAP_WAIT,   // hold everything
    MAP_SCAN,   // rotate one byte, update search
    MAP_SET,    // rotate one byte, set bits in range
    MAP_CLR     // rotate one byte, clear bits in range
  } map_cmd_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_MARK,
    S_LOOKUP,
    S_CLEAR,
    S_DONE
  } state_e;

  typedef struct packed {
    map_cmd_e             cmd;
    logic [LEN_W-1:0]     need;
    logic [LEN_W-1:0]     limit;
    logic [CHUNK_W-1:0]   lo;
    logic [LEN_W-1:0]     len;
  } map_req_t;

  typedef struct packed {
    logic                 last;
    logic                 found;
    logic [CHUNK_W-1:0]   start;
  } map_stat_t;

endpackage

>>> src/cbffa_ram.sv
// Generic single-write, single-read RAM with registered read data
`timescale 1ns / 1ps
module cbffa_ram #(
  parameter int unsigned Width = 9,
  parameter int unsigned Depth = 256,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/cbffa_map.sv
// Used-chunk bitmap as a rotating byte shift register with serial search and marking
`timescale 1ns / 1ps
module cbffa_map (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cbffa_pkg::map_req_t  req_i,
  output cbffa_pkg::map_stat_t stat_o
);
  import cbffa_pkg::*;

  logic [NUM_CHUNKS-1:0] map_q, map_d;
  logic [BCNT_W-1:0]     cnt_q, cnt_d;
  logic [LEN_W-1:0]      gap_q, gap_d;
  logic [CHUNK_W-1:0]    start_q, start_d;
  logic                  found_q, found_d;

  logic [DIGIT_W-1:0]    tap, tap_new, mask;
  logic [CHUNK_W-1:0]    idx;
  logic [LEN_W:0]        range_lo, range_hi, idx_ext;
  logic                  advance;

  // Byte at the tap holds chunks cnt*8 .. cnt*8+7, first chunk in the MSB
  assign tap = map_q[DIGIT_W-1:0];

  // search one byte, build the range mask
  always_comb begin
    gap_d    = gap_q;
    start_d  = start_q;
    found_d  = found_q;
    mask     = '0;
    idx      = '0;
    idx_ext  = '0;
    range_lo = {2'b00, req_i.lo};
    range_hi = {2'b00, req_i.lo} + {1'b0, req_i.len};
    for (int j = 0; j < DIGIT_W; j++) begin
      idx     = {cnt_q, DIGIT_SEL_W'(j)};
      idx_ext = {2'b00, idx};
      mask[DIGIT_W-1-j] = (idx_ext >= range_lo) && (idx_ext < range_hi);
      if (req_i.cmd == MAP_SCAN && !found_d && ({1'b0, idx} < req_i.limit)) begin
        if (tap[DIGIT_W-1-j]) begin
          gap_d   = '0;
          start_d = idx + 1'b1;
        end else begin
          gap_d = gap_d + 1'b1;
        end
        if (gap_d >= req_i.need) begin
          found_d = 1'b1;
        end
      end
    end
    if (req_i.cmd == MAP_IDLE) begin
      gap_d   = '0;
      start_d = '0;
      found_d = 1'b0;
    end
  end

  // modify the tap byte and rotate it to the far end
  always_comb begin
    unique case (req_i.cmd)
      MAP_SET: tap_new = tap | mask;
      MAP_CLR: tap_new = tap & ~mask;
      default: tap_new = tap;
    endcase
    advance = (req_i.cmd == MAP_SCAN) || (req_i.cmd == MAP_SET) || (req_i.cmd == MAP_CLR);
    map_d   = advance ? {tap_new, map_q[NUM_CHUNKS-1:DIGIT_W]} : map_q;
    cnt_d   = advance ? cnt_q + 1'b1 : cnt_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_q   <= '0;
      cnt_q   <= '0;
      gap_q   <= '0;
      start_q <= '0;
      found_q <= 1'b0;
    end else begin
      map_q   <= map_d;
      cnt_q   <= cnt_d;
      gap_q   <= gap_d;
      start_q <= start_d;
      found_q <= found_d;
    end
  end

  assign stat_o.last  = (cnt_q == '1);
  assign stat_o.found = found_q;
  assign stat_o.start = start_q;

endmodule

>>> src/chunk_bitmap_first_fit_allocator_top.sv
// Top level: first-fit chunk allocator over a bitmap pool
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+--------------------------------------
//   request | in        | in_valid_i/in_ready_o  | opcode_i, request_bytes_i,
//           |           |                        | release_address_i
//   result  | out       | out_valid_o/out_ready_i| status_o, granted_address_o
//   config  | in        | cfg_we_i               | cfg_wdata_i (active_chunks)
//
// One request at a time. The 256-chunk map rotates a byte per cycle in each pass. A granted
// allocate runs a scan pass, a decide step and a mark pass to its result; no room, a scan
// pass and a decide step; a freed address, a lookup and a clear pass; an unknown address, a lookup.
// Reset empties the map and clears the run-length valid bits at once; no clearing pass.
// A finished result waits in the output register while the next request is taken;
// the block stalls only when a second result is ready before the first is transferred.
`timescale 1ns / 1ps
module chunk_bitmap_first_fit_allocator_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           opcode_i,
  input  logic [cbffa_pkg::REQ_W-1:0]    request_bytes_i,
  input  logic [cbffa_pkg::ADDR_W-1:0]   release_address_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [cbffa_pkg::ST_W-1:0]     status_o,
  output logic [cbffa_pkg::ADDR_W-1:0]   granted_address_o,
  input  logic                           cfg_we_i,
  input  logic [cbffa_pkg::LEN_W-1:0]    cfg_wdata_i
);
  import cbffa_pkg::*;

  state_e                state_q, state_d;
  logic [LEN_W-1:0]      active_q;
  logic [LEN_W-1:0]      limit;
  logic [LEN_W-1:0]      need_q, need_d;
  logic [ADDR_W-1:0]     addr_q, addr_d;
  logic [LEN_W-1:0]      len_q, len_d;
  logic [NUM_CHUNKS-1:0] valid_q;
  logic                  valid_set, valid_clr;
  logic [CHUNK_W-1:0]    free_chunk;
  logic [SUM_W-1:0]      need_sum;

  status_e               res_status_q, res_status_d;
  logic [ADDR_W-1:0]     res_addr_q, res_addr_d;
  logic                  res_load;
  logic                  out_load;
  logic                  out_valid_q;
  status_e               out_status_q;
  logic [ADDR_W-1:0]     out_addr_q;

  map_req_t              map_req;
  map_stat_t             map_stat;

  logic                  ram_we;
  logic [CHUNK_W-1:0]    ram_waddr, ram_raddr;
  logic [LEN_W-1:0]      ram_wdata, ram_rdata;

  // clamp the active pool to the map size
  assign limit      = (active_q > LEN_W'(NUM_CHUNKS)) ? LEN_W'(NUM_CHUNKS) : active_q;
  assign free_chunk = addr_q[ADDR_W-1:OFF_W];
  assign need_sum   = {1'b0, request_bytes_i} + SUM_W'(HEADER_BYTES + CHUNK_BYTES - 1);

  cbffa_map u_map (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (map_req),
    .stat_o (map_stat)
  );

  cbffa_ram #(
    .Width (LEN_W),
    .Depth (NUM_CHUNKS)
  ) u_len_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // sequence one request through scan, mark, lookup and clear
  always_comb begin
    state_d      = state_q;
    in_ready_o   = 1'b0;
    need_d       = need_q;
    addr_d       = addr_q;
    len_d        = len_q;
    map_req.cmd  = MAP_WAIT;
    map_req.need = need_q;
    map_req.limit = limit;
    map_req.lo   = map_stat.start;
    map_req.len  = need_q;
    ram_we       = 1'b0;
    ram_waddr    = map_stat.start;
    ram_wdata    = need_q;
    ram_raddr    = release_address_i[ADDR_W-1:OFF_W];
    valid_set    = 1'b0;
    valid_clr    = 1'b0;
    res_load     = 1'b0;
    res_status_d = ST_GRANTED;
    res_addr_d   = '0;
    out_load     = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        in_ready_o  = 1'b1;
        map_req.cmd = MAP_IDLE;
        if (in_valid_i) begin
          if (op_e'(opcode_i) == OP_ALLOC) begin
            need_d  = need_sum[SUM_W-1:OFF_W];
            state_d = S_SCAN;
          end else begin
            addr_d  = release_address_i;
            state_d = S_LOOKUP;
          end
        end
      end
      S_SCAN: begin
        map_req.cmd = MAP_SCAN;
        if (map_stat.last) begin
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (map_stat.found) begin
          ram_we    = 1'b1;
          valid_set = 1'b1;
          state_d   = S_MARK;
        end else begin
          res_load     = 1'b1;
          res_status_d = ST_NO_ROOM;
          state_d      = S_DONE;
        end
      end
      S_MARK: begin
        map_req.cmd = MAP_SET;
        if (map_stat.last) begin
          res_load     = 1'b1;
          res_status_d = ST_GRANTED;
          res_addr_d   = {map_stat.start, OFF_W'(HEADER_BYTES)};
          state_d      = S_DONE;
        end
      end
      S_LOOKUP: begin
        if (addr_q[OFF_W-1:0] == OFF_W'(HEADER_BYTES) && valid_q[free_chunk]) begin
          len_d     = ram_rdata;
          valid_clr = 1'b1;
          state_d   = S_CLEAR;
        end else begin
          res_load     = 1'b1;
          res_status_d = ST_UNKNOWN;
          state_d      = S_DONE;
        end
      end
      S_CLEAR: begin
        map_req.cmd = MAP_CLR;
        map_req.lo  = free_chunk;
        map_req.len = len_q;
        if (map_stat.last) begin
          res_load     = 1'b1;
          res_status_d = ST_FREED;
          state_d      = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // hold the pool size register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= LEN_W'(NUM_CHUNKS);
    end else if (cfg_we_i) begin
      active_q <= cfg_wdata_i;
    end
  end

  // track which run-length entries hold a run
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (valid_set) begin
        valid_q[map_stat.start] <= 1'b1;
      end
      if (valid_clr) begin
        valid_q[free_chunk] <= 1'b0;
      end
    end
  end

  // request and result payload
  always_ff @(posedge clk_i) begin
    need_q <= need_d;
    addr_q <= addr_d;
    len_q  <= len_d;
    if (res_load) begin
      res_status_q <= res_status_d;
      res_addr_q   <= res_addr_d;
    end
    if (out_load) begin
      out_status_q <= res_status_q;
      out_addr_q   <= res_addr_q;
    end
  end

  // output register valid: set on load, drop on transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_o          = out_status_q;
  assign granted_address_o = out_addr_q;

endmodule

>>> src/cbffa_checker.sv
// Port-level checker for the allocator top level and its bind
`timescale 1ns / 1ps
`include "chunk_bitmap_first_fit_allocator_top_assert.svh"
module cbffa_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_ready_o,
  input logic                           out_valid_o,
  input logic                           out_ready_i,
  input logic [cbffa_pkg::ST_W-1:0]     status_o,
  input logic [cbffa_pkg::ADDR_W-1:0]   granted_address_o
);
  import cbffa_pkg::*;

  // a result stays offered until transferred
  `CBFFA_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o, "result dropped")

  // the block is busy right after taking a request
  `CBFFA_ASSERT_NEXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o, "ready after accept")

  // only a grant carries an address
  `CBFFA_ASSERT_SAME(a_addr_zero, out_valid_o && status_o != ST_GRANTED, granted_address_o == '0, "address on non-grant")

  // a granted address points past the header of a chunk
  `CBFFA_ASSERT_SAME(a_addr_header, out_valid_o && status_o == ST_GRANTED, granted_address_o[OFF_W-1:0] == OFF_W'(HEADER_BYTES), "grant off header")

endmodule

bind chunk_bitmap_first_fit_allocator_top cbffa_checker u_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_valid_i),
  .in_ready_o        (in_ready_o),
  .out_valid_o       (out_valid_o),
  .out_ready_i       (out_ready_i),
  .status_o          (status_o),
  .granted_address_o (granted_address_o)
);
